/* hdl/sacl_pkg.sv */
`default_nettype none
package sacl_pkg;

  localparam int ADDR_W     = 64;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int SB_W       = 3;
  localparam int BB_W       = 6;
  localparam int WU_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

endpackage
`default_nettype wire

/* hdl/sacl_if.sv */
`default_nettype none
interface sacl_in_if import sacl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if import sacl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             evicted;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  modport source (output valid, output hit, output evicted, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink   (input valid, input hit, input evicted, input hit_total,
                  input miss_total, input eviction_total, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

/* hdl/sacl_ram.sv */
`default_nettype none
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/sacl_front.sv */
`default_nettype none
module sacl_front import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sacl_in_if.sink                in_ch,
  input  wire logic [SB_W-1:0]   set_bits,
  input  wire logic [BB_W-1:0]   block_bits,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output logic      [SET_W-1:0]  q_set,
  output logic      [ADDR_W-1:0] q_tag
);

  // largest k with 2^k <= MAX_SETS
  localparam int SB_LIM = $clog2(MAX_SETS + 1) - 1;

  logic [SB_W-1:0]   sb_eff;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W:0]    set_mask;
  logic [SET_W-1:0]  set_c;
  logic [BB_W:0]     tag_sh;
  logic [ADDR_W-1:0] tag_c;

  logic [SET_W-1:0]  q_set_r [2];
  logic [ADDR_W-1:0] q_tag_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  always_comb begin
    sb_eff   = (int'(set_bits) > SB_LIM) ? SB_W'(SB_LIM) : set_bits;
    shifted  = in_ch.address >> block_bits;
    set_mask = ({{SET_W{1'b0}}, 1'b1} << sb_eff) - {{SET_W{1'b0}}, 1'b1};
    set_c    = shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    // shift of 64 or more leaves a zero tag
    tag_sh   = {1'b0, block_bits} + {{(BB_W + 1 - SB_W){1'b0}}, sb_eff};
    tag_c    = in_ch.address >> tag_sh;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_set       = q_set_r[rd_ptr_r];
  assign q_tag       = q_tag_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_set_r[wr_ptr_r] <= set_c;
      q_tag_r[wr_ptr_r] <= tag_c;
    end
  end

endmodule
`default_nettype wire

/* hdl/sacl_back.sv */
`default_nettype none
module sacl_back import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire logic [SET_W-1:0]  q_set,
  input  wire logic [ADDR_W-1:0] q_tag,
  input  wire logic [WU_W-1:0]   ways_used,
  sacl_out_if.source             out_ch
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LVLS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int P      = 1 << LVLS;
  localparam int LVL_W  = (LVLS > 1) ? $clog2(LVLS) : 1;
  localparam int LINE_W = 1 + ADDR_W + STAMP_W;
  localparam int ROW_W  = MAX_WAYS * LINE_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_TREE = 4'b0100,
    ST_PICK = 4'b1000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [SET_W-1:0]   set_r;
  logic [ADDR_W-1:0]  tag_r;
  logic [MAX_SETS-1:0] row_vld_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   hits_r, miss_r, evict_cnt_r;
  logic               out_vld_r, out_hit_r, out_evict_r;
  logic               look_hit_r, evict_r;
  logic [WAY_W-1:0]   vic_idx_r;
  logic [LVL_W-1:0]   lvl_r;

  // min-stamp reduction tree, one level per cycle
  logic               nd_pres_r  [P];
  logic [WAY_W-1:0]   nd_idx_r   [P];
  logic [STAMP_W-1:0] nd_stamp_r [P];
  logic               red_pres   [P];
  logic [WAY_W-1:0]   red_idx    [P];
  logic [STAMP_W-1:0] red_stamp  [P];

  logic [ROW_W-1:0]   rd_data, wr_data;
  logic               ram_re, ram_we;

  logic               row_ok;
  logic [P-1:0]       way_v, way_en, hit_vec, free_vec;
  logic [ADDR_W-1:0]  way_tag   [P];
  logic [STAMP_W-1:0] way_stamp [P];
  logic [WAY_W-1:0]   hit_idx, free_idx, vic;
  logic               any_hit, any_free, pick_fire;
  logic [STAMP_W-1:0] stamp_inc;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (q_set),
    .rdata (rd_data)
  );

  // way lookup
  always_comb begin
    row_ok = row_vld_r[set_r];
    for (int w = 0; w < P; w++) begin
      way_v[w]     = 1'b0;
      way_tag[w]   = '0;
      way_stamp[w] = '0;
      way_en[w]    = 1'b0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_v[w]     = rd_data[w*LINE_W + LINE_W - 1];
      way_tag[w]   = rd_data[w*LINE_W + STAMP_W +: ADDR_W];
      way_stamp[w] = rd_data[w*LINE_W +: STAMP_W];
      // ways_used of zero still enables way 0
      way_en[w]    = (w == 0) || (w < int'(ways_used));
    end
    for (int w = 0; w < P; w++) begin
      hit_vec[w]  = row_ok && way_v[w] && way_en[w] && (way_tag[w] == tag_r);
      free_vec[w] = way_en[w] && !(row_ok && way_v[w]);
    end
    any_hit  = |hit_vec;
    any_free = |free_vec;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = P - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_idx = WAY_W'(w);
      end
    end
  end

  // tie keeps the left (lower) index
  always_comb begin
    for (int i = 0; i < P; i++) begin
      red_pres[i]  = nd_pres_r[i];
      red_idx[i]   = nd_idx_r[i];
      red_stamp[i] = nd_stamp_r[i];
    end
    for (int i = 0; i < P / 2; i++) begin
      if (nd_pres_r[2*i+1] &&
          (!nd_pres_r[2*i] || (nd_stamp_r[2*i+1] < nd_stamp_r[2*i]))) begin
        red_pres[i]  = 1'b1;
        red_idx[i]   = nd_idx_r[2*i+1];
        red_stamp[i] = nd_stamp_r[2*i+1];
      end else begin
        red_pres[i]  = nd_pres_r[2*i];
        red_idx[i]   = nd_idx_r[2*i];
        red_stamp[i] = nd_stamp_r[2*i];
      end
    end
  end

  // line update
  always_comb begin
    stamp_inc = stamp_r + 1'b1;
    vic       = evict_r ? nd_idx_r[0] : vic_idx_r;
    wr_data   = row_ok ? rd_data : '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == vic) begin
        wr_data[w*LINE_W +: LINE_W] = {1'b1, tag_r, stamp_inc};
      end
    end
  end

  assign pick_fire = (state_r == ST_PICK) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ram_re    = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (any_hit || any_free || (LVLS == 0)) begin
          state_nxt = ST_PICK;
        end else begin
          state_nxt = ST_TREE;
        end
      end
      ST_TREE: begin
        if (lvl_r == LVL_W'(LVLS - 1)) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_fire) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      stamp_r     <= '0;
      hits_r      <= '0;
      miss_r      <= '0;
      evict_cnt_r <= '0;
      out_vld_r   <= 1'b0;
      lvl_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOOK) begin
        lvl_r <= '0;
      end else if (state_r == ST_TREE) begin
        lvl_r <= lvl_r + 1'b1;
      end
      if (pick_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (pick_fire) begin
        row_vld_r[set_r]  <= 1'b1;
        stamp_r           <= stamp_inc;
        if (look_hit_r) begin
          hits_r <= (hits_r == '1) ? hits_r : hits_r + 1'b1;
        end else begin
          miss_r <= (miss_r == '1) ? miss_r : miss_r + 1'b1;
        end
        if (evict_r) begin
          evict_cnt_r <= (evict_cnt_r == '1) ? evict_cnt_r : evict_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && q_valid) begin
      set_r <= q_set;
      tag_r <= q_tag;
    end
    if (state_r == ST_LOOK) begin
      look_hit_r <= any_hit;
      evict_r    <= !any_hit && !any_free;
      vic_idx_r  <= any_hit ? hit_idx : free_idx;
      for (int w = 0; w < P; w++) begin
        nd_pres_r[w]  <= way_en[w];
        nd_idx_r[w]   <= WAY_W'(w);
        nd_stamp_r[w] <= way_stamp[w];
      end
    end else if (state_r == ST_TREE) begin
      for (int w = 0; w < P; w++) begin
        nd_pres_r[w]  <= red_pres[w];
        nd_idx_r[w]   <= red_idx[w];
        nd_stamp_r[w] <= red_stamp[w];
      end
    end
    if (pick_fire) begin
      out_hit_r   <= look_hit_r;
      out_evict_r <= evict_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.evicted        = out_evict_r;
  assign out_ch.hit_total      = hits_r;
  assign out_ch.miss_total     = miss_r;
  assign out_ch.eviction_total = evict_cnt_r;

endmodule
`default_nettype wire

/* hdl/set_assoc_lru_cache_tag_model_core.sv */
// Flow: an accepted item waits in the front FIFO, then the back end reads its set row (IDLE),
//   checks the ways (LOOK), walks the LRU min-stamp tree when a valid line is replaced (TREE, one level/cycle)
//   and writes the row and registers the result (PICK), which waits while the output is not ready.
// The back end takes a new item only after the read-modify-write of one set row through the row RAM.
// Reset (rst_n low, synchronous): all sets invalid via per-set valid flops, stamp and totals
//   zero, set_bits 0, block_bits 0, ways_used 1. No clearing pass.
`default_nettype none
module set_assoc_lru_cache_tag_model_core import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sacl_in_if.sink    in_ch,
  sacl_out_if.source out_ch,
  sacl_cfg_if.sink   cfg_ch
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  logic [SB_W-1:0]   set_bits_r;
  logic [BB_W-1:0]   block_bits_r;
  logic [WU_W-1:0]   ways_used_r;
  logic              q_valid, q_ready;
  logic [SET_W-1:0]  q_set;
  logic [ADDR_W-1:0] q_tag;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_used_r  <= WU_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_SET_BITS:   set_bits_r   <= cfg_ch.data[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_ch.data[BB_W-1:0];
        CFG_WAYS_USED:  ways_used_r  <= cfg_ch.data[WU_W-1:0];
        default: ;
      endcase
    end
  end

  sacl_front #(.MAX_SETS(MAX_SETS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .set_bits   (set_bits_r),
    .block_bits (block_bits_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_set      (q_set),
    .q_tag      (q_tag)
  );

  sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_set     (q_set),
    .q_tag     (q_tag),
    .ways_used (ways_used_r),
    .out_ch    (out_ch)
  );

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.evicted))
    else $error("hit result flagged as eviction");

  a_evict_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted) |-> (out_ch.eviction_total != '0))
    else $error("eviction reported with zero eviction total");

  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |-> (out_ch.miss_total != '0))
    else $error("miss reported with zero miss total");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |-> (out_ch.hit_total != '0))
    else $error("hit reported with zero hit total");

endmodule
`default_nettype wire
